>>> hdl/sha1mh_pkg.sv
// ============================================================================
// SHA-1 message hasher package
// Shared constants, command and status types, and the SHA-1 constant tables
// used by the controller and the datapath.
// ============================================================================
package sha1mh_pkg;

    // Block geometry.
    localparam int BLOCK_BYTES = 64;
    localparam int LEN_POS     = 56;
    localparam int HASH_WORDS  = 5;
    localparam int ROUNDS      = 80;

    // Operation codes of an input request.
    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    // Padding marker byte.
    localparam logic [7:0] PAD_MARK = 8'h80;

    // Source of the byte shifted into the block buffer.
    typedef enum logic [1:0] {
        BSEL_DATA,
        BSEL_MARK,
        BSEL_ZERO,
        BSEL_LEN
    } byte_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       push;      // shift one byte into the block buffer
        byte_sel_t  byte_sel;  // which byte to shift in
        logic       load;      // copy chaining words into working registers
        logic       round;     // run one compression round
        logic [1:0] stage;     // round group 0..3, selects f and K
        logic       fold;      // add working registers into chaining words
        logic       init;      // return to the start of a new message
        logic [2:0] out_idx;   // digest word on the output
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [6:0] fill_count;
    } dp_status_t;

    // Standard SHA-1 initial chaining value, word by word.
    function automatic logic [31:0] init_word(input logic [2:0] idx);
        logic [31:0] w;
        case (idx)
            3'd0:    w = 32'h67452301;
            3'd1:    w = 32'hEFCDAB89;
            3'd2:    w = 32'h98BADCFE;
            3'd3:    w = 32'h10325476;
            3'd4:    w = 32'hC3D2E1F0;
            default: w = 32'h00000000;
        endcase
        return w;
    endfunction

    // Round constant for each group of twenty rounds.
    function automatic logic [31:0] round_k(input logic [1:0] stage);
        logic [31:0] k;
        case (stage)
            2'd0:    k = 32'h5A827999;
            2'd1:    k = 32'h6ED9EBA1;
            2'd2:    k = 32'h8F1BBCDC;
            default: k = 32'hCA62C1D6;
        endcase
        return k;
    endfunction

    // Round function for each group of twenty rounds.
    function automatic logic [31:0] round_f(input logic [1:0]  stage,
                                            input logic [31:0] b,
                                            input logic [31:0] c,
                                            input logic [31:0] d);
        logic [31:0] f;
        case (stage)
            2'd0:    f = (b & c) | (~b & d);
            2'd2:    f = (b & c) | (b & d) | (c & d);
            default: f = b ^ c ^ d;
        endcase
        return f;
    endfunction

endpackage

>>> hdl/sha1mh_stream_if.sv
// ============================================================================
// SHA-1 message hasher channel interfaces
// Valid/ready channels for the byte feed and for the digest words.
// ============================================================================

// Input channel: one byte append or one finish request.
interface sha1mh_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] data_byte;

    modport source (output valid, output operation, output data_byte, input ready);
    modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

// Output channel: one digest word per request.
interface sha1mh_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    logic        status;

    modport source (output valid, output digest_word, output word_index,
                    output last_word, output status, input ready);
    modport sink   (input valid, input digest_word, input word_index,
                    input last_word, input status, output ready);
endinterface

>>> hdl/sha1mh_datapath.sv
// ============================================================================
// SHA-1 message hasher datapath
// Block buffer as a byte/word shift line, message schedule, round logic,
// chaining words and message length counter.
// ============================================================================
module sha1mh_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sha1mh_pkg::dp_cmd_t    cmd,
    input  logic [7:0]             data_byte,
    output sha1mh_pkg::dp_status_t stat,
    output logic [31:0]            digest_word,
    output logic                   overflow
);

    // Block buffer: byte 0 of the block sits in the top byte.
    logic [511:0] blk_reg, blk_next;
    logic [31:0]  a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0]  a_next, b_next, c_next, d_next, e_next;
    logic [31:0]  chain_reg [0:4];
    logic [31:0]  chain_next [0:4];
    logic [6:0]   fill_reg, fill_next;
    logic [63:0]  len_reg, len_next;
    logic         ovf_reg, ovf_next;

    logic [7:0]   push_byte;
    logic [7:0]   len_byte;
    logic [31:0]  w_cur;
    logic [31:0]  w_mix;
    logic [31:0]  w_new;
    logic [31:0]  temp;
    logic [63:0]  len_sum;

    // Length byte for the current buffer position, most significant first.
    assign len_byte = len_reg[{~fill_reg[2:0], 3'b000} +: 8];

    // Byte shifted into the buffer.
    always_comb
    begin
        case (cmd.byte_sel)
            sha1mh_pkg::BSEL_DATA: push_byte = data_byte;
            sha1mh_pkg::BSEL_MARK: push_byte = sha1mh_pkg::PAD_MARK;
            sha1mh_pkg::BSEL_LEN:  push_byte = len_byte;
            default:               push_byte = 8'h00;
        endcase
    end

    // Message schedule over a sliding window of sixteen words.
    assign w_cur = blk_reg[511:480];
    assign w_mix = blk_reg[95:64] ^ blk_reg[255:224] ^ blk_reg[447:416] ^ w_cur;
    assign w_new = {w_mix[30:0], w_mix[31]};

    // One compression round.
    assign temp = {a_reg[26:0], a_reg[31:27]}
                + sha1mh_pkg::round_f(cmd.stage, b_reg, c_reg, d_reg)
                + e_reg + w_cur + sha1mh_pkg::round_k(cmd.stage);

    assign len_sum = len_reg + 64'd8;

    // Next-state logic for buffer, working and chaining registers.
    always_comb
    begin
        blk_next  = blk_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        c_next    = c_reg;
        d_next    = d_reg;
        e_next    = e_reg;
        fill_next = fill_reg;
        len_next  = len_reg;
        ovf_next  = ovf_reg;
        for (int i = 0; i < sha1mh_pkg::HASH_WORDS; i++)
        begin
            chain_next[i] = chain_reg[i];
        end

        if (cmd.push)
        begin
            blk_next  = {blk_reg[503:0], push_byte};
            fill_next = fill_reg + 7'd1;
            if (cmd.byte_sel == sha1mh_pkg::BSEL_DATA)
            begin
                len_next = len_sum;
                if (len_sum == 64'd0)
                begin
                    ovf_next = 1'b1;
                end
            end
        end

        if (cmd.load)
        begin
            a_next = chain_reg[0];
            b_next = chain_reg[1];
            c_next = chain_reg[2];
            d_next = chain_reg[3];
            e_next = chain_reg[4];
        end

        if (cmd.round)
        begin
            blk_next = {blk_reg[479:0], w_new};
            a_next   = temp;
            b_next   = a_reg;
            c_next   = {b_reg[1:0], b_reg[31:2]};
            d_next   = c_reg;
            e_next   = d_reg;
        end

        if (cmd.fold)
        begin
            chain_next[0] = chain_reg[0] + a_reg;
            chain_next[1] = chain_reg[1] + b_reg;
            chain_next[2] = chain_reg[2] + c_reg;
            chain_next[3] = chain_reg[3] + d_reg;
            chain_next[4] = chain_reg[4] + e_reg;
            fill_next     = 7'd0;
        end

        if (cmd.init)
        begin
            for (int i = 0; i < sha1mh_pkg::HASH_WORDS; i++)
            begin
                chain_next[i] = sha1mh_pkg::init_word(3'(i));
            end
            fill_next = 7'd0;
            len_next  = 64'd0;
            ovf_next  = 1'b0;
        end
    end

    // Message state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < sha1mh_pkg::HASH_WORDS; i++)
            begin
                chain_reg[i] <= sha1mh_pkg::init_word(3'(i));
            end
            fill_reg <= 7'd0;
            len_reg  <= 64'd0;
            ovf_reg  <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < sha1mh_pkg::HASH_WORDS; i++)
            begin
                chain_reg[i] <= chain_next[i];
            end
            fill_reg <= fill_next;
            len_reg  <= len_next;
            ovf_reg  <= ovf_next;
        end
    end

    // Payload registers without reset.
    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        c_reg   <= c_next;
        d_reg   <= d_next;
        e_reg   <= e_next;
    end

    // Digest word selection and status.
    always_comb
    begin
        case (cmd.out_idx)
            3'd0:    digest_word = chain_reg[0];
            3'd1:    digest_word = chain_reg[1];
            3'd2:    digest_word = chain_reg[2];
            3'd3:    digest_word = chain_reg[3];
            default: digest_word = chain_reg[4];
        endcase
    end

    assign stat.fill_count = fill_reg;
    assign overflow        = ovf_reg;

endmodule

>>> hdl/sha1mh_ctrl.sv
// ============================================================================
// SHA-1 message hasher controller
// Sequences byte appends, padding, the 80 compression rounds and the
// delivery of the five digest words.
// ============================================================================
module sha1mh_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_operation,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [2:0]             out_index,
    output logic                   out_last,
    input  sha1mh_pkg::dp_status_t stat,
    output sha1mh_pkg::dp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD_MARK,
        S_PAD_ZERO,
        S_PAD_LEN,
        S_LOAD,
        S_ROUND,
        S_FOLD,
        S_OUT
    } state_t;

    localparam logic [6:0] FILL_LAST = 7'(sha1mh_pkg::BLOCK_BYTES - 1);
    localparam logic [6:0] FILL_LEN  = 7'(sha1mh_pkg::LEN_POS);
    localparam logic [6:0] RND_LAST  = 7'(sha1mh_pkg::ROUNDS - 1);
    localparam logic [2:0] IDX_LAST  = 3'(sha1mh_pkg::HASH_WORDS - 1);

    state_t     state_reg, state_next;
    state_t     ret_reg, ret_next;
    logic [6:0] rnd_reg, rnd_next;
    logic [2:0] idx_reg, idx_next;
    logic       block_full;

    assign block_full = (stat.fill_count == FILL_LAST);

    // Next state and datapath commands.
    always_comb
    begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        rnd_next     = rnd_reg;
        idx_next     = idx_reg;
        cmd          = '0;
        cmd.byte_sel = sha1mh_pkg::BSEL_DATA;
        cmd.out_idx  = idx_reg;
        if (rnd_reg < 7'd20)
        begin
            cmd.stage = 2'd0;
        end
        else if (rnd_reg < 7'd40)
        begin
            cmd.stage = 2'd1;
        end
        else if (rnd_reg < 7'd60)
        begin
            cmd.stage = 2'd2;
        end
        else
        begin
            cmd.stage = 2'd3;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_operation == sha1mh_pkg::OP_APPEND)
                    begin
                        cmd.push = 1'b1;
                        if (block_full)
                        begin
                            ret_next   = S_IDLE;
                            state_next = S_LOAD;
                        end
                    end
                    else
                    begin
                        state_next = S_PAD_MARK;
                    end
                end
            end
            S_PAD_MARK:
            begin
                cmd.push     = 1'b1;
                cmd.byte_sel = sha1mh_pkg::BSEL_MARK;
                state_next   = S_PAD_ZERO;
                if (block_full)
                begin
                    ret_next   = S_PAD_ZERO;
                    state_next = S_LOAD;
                end
            end
            S_PAD_ZERO:
            begin
                if (stat.fill_count == FILL_LEN)
                begin
                    state_next = S_PAD_LEN;
                end
                else
                begin
                    cmd.push     = 1'b1;
                    cmd.byte_sel = sha1mh_pkg::BSEL_ZERO;
                    if (block_full)
                    begin
                        ret_next   = S_PAD_ZERO;
                        state_next = S_LOAD;
                    end
                end
            end
            S_PAD_LEN:
            begin
                cmd.push     = 1'b1;
                cmd.byte_sel = sha1mh_pkg::BSEL_LEN;
                if (block_full)
                begin
                    ret_next   = S_OUT;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.load   = 1'b1;
                rnd_next   = 7'd0;
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                cmd.round = 1'b1;
                rnd_next  = rnd_reg + 7'd1;
                if (rnd_reg == RND_LAST)
                begin
                    state_next = S_FOLD;
                end
            end
            S_FOLD:
            begin
                cmd.fold   = 1'b1;
                idx_next   = 3'd0;
                state_next = ret_reg;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == IDX_LAST)
                    begin
                        cmd.init   = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
            rnd_reg   <= 7'd0;
            idx_reg   <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            rnd_reg   <= rnd_next;
            idx_reg   <= idx_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign out_index = idx_reg;
    assign out_last  = (idx_reg == IDX_LAST);

`ifndef SYNTHESIS
    // Input and output sides are never open at the same time.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while a digest word is pending");

    // A digest word index never passes the last word.
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (idx_reg <= IDX_LAST))
        else $error("digest word index out of range");

    // The round counter stays within the 80 rounds.
    a_rnd_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROUND) |-> (rnd_reg <= RND_LAST))
        else $error("round counter out of range");

    // The buffer never holds more than a block outside a compression.
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (stat.fill_count < 7'(sha1mh_pkg::BLOCK_BYTES)))
        else $error("block buffer overfilled");

    // The last digest word returns the block to accepting requests.
    a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && out_last) |=> in_ready)
        else $error("block not idle after last digest word");
`endif

endmodule

>>> hdl/sha1_message_hasher_unit.sv
// ============================================================================
// SHA-1 message hasher unit
// Byte-serial SHA-1: appends message bytes, pads on finish and returns the
// 160-bit digest as five 32-bit words.
// ============================================================================
//
//   Channel  Dir  Payload                                   Per request
//   feed     in   operation, data_byte                      append or finish
//   digest   out  digest_word, word_index, last_word,       one digest word,
//                 status                                    five per finish
//
// An append is accepted at once; the append that fills a block also runs a
// compression (load, 80 rounds in one round unit, fold). After a finish the unit
// shifts in padding at one byte per cycle between compressions up to the end of
// the block, with an idle step before the length field and a compression per
// full block, then shows five words, one per cycle while digest is ready.
// Reset (rst_n, asynchronous) restores the initial chaining value.
// feed is not ready while padding is shifted in, a block is compressed or digest words are pending.
//
module sha1_message_hasher_unit (
    input logic       clk,
    input logic       rst_n,
    sha1mh_in_if.sink     feed,
    sha1mh_out_if.source  digest
);

    sha1mh_pkg::dp_cmd_t    cmd;
    sha1mh_pkg::dp_status_t stat;
    logic                   overflow;

    // Sequencer.
    sha1mh_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (feed.valid),
        .in_operation (feed.operation),
        .in_ready     (feed.ready),
        .out_valid    (digest.valid),
        .out_ready    (digest.ready),
        .out_index    (digest.word_index),
        .out_last     (digest.last_word),
        .stat         (stat),
        .cmd          (cmd)
    );

    // Buffer, schedule, rounds and chaining state.
    sha1mh_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .data_byte   (feed.data_byte),
        .stat        (stat),
        .digest_word (digest.digest_word),
        .overflow    (overflow)
    );

    assign digest.status = overflow;

endmodule

>>> test/tb_top.sv
// ============================================================================
// SHA-1 message hasher testbench
// Feeds byte and finish requests into the feed channel with random idle gaps.
// A built-in SHA-1 predictor computes the digest of each finished message.
// Every digest word is checked in order against the predicted words. The run
// covers directed messages, padding-boundary tails and random messages, with
// long back-pressure on the digest channel and sender pauses.
// ============================================================================
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // SHA-1 initial chaining value and round constants.
    localparam logic [31:0] IV_WORD [sha1mh_pkg::HASH_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0};
    localparam logic [31:0] K_CH  = 32'h5A827999;
    localparam logic [31:0] K_PAR = 32'h6ED9EBA1;
    localparam logic [31:0] K_MAJ = 32'h8F1BBCDC;
    localparam logic [31:0] K_END = 32'hCA62C1D6;

    localparam int unsigned LONG_HOLD    = 400;
    localparam int unsigned REQUEST_GOAL = 250;
    localparam int unsigned SETTLE_CYCLES = 200;

    typedef struct packed {
        logic       operation;
        logic [7:0] data_byte;
    } feed_request_t;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
        logic        status;
    } digest_word_t;

    logic clk = 1'b0;
    logic rst_n;

    sha1mh_in_if  feed ();
    sha1mh_out_if digest ();

    sha1_message_hasher_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .feed   (feed),
        .digest (digest)
    );

    // Clock generation.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Pending requests and predicted digest words.
    feed_request_t request_q[$];
    digest_word_t  digest_expect_q[$];

    // Predictor state.
    logic [31:0] chain_h [sha1mh_pkg::HASH_WORDS];
    logic [7:0]  block_buf [sha1mh_pkg::BLOCK_BYTES];
    int unsigned buf_fill;
    logic [63:0] msg_bits;
    logic        len_wrapped;

    // Run statistics.
    int unsigned queued_requests = 0;
    int unsigned bytes_hashed = 0;
    int unsigned messages_hashed = 0;
    int unsigned tails_one_block = 0;
    int unsigned tails_two_block = 0;
    int unsigned tails_aligned = 0;
    int unsigned words_checked = 0;
    int unsigned fail_count = 0;

    // Handshake pacing state.
    int unsigned   tx_idle;
    bit            tx_steady;
    feed_request_t next_req;
    int unsigned   rx_idle;
    bit            rx_steady;
    int unsigned   rx_pick;
    int unsigned   rx_hold_left;
    int unsigned   rx_hold_asked = 0;
    int unsigned   rx_hold_given;

    // Mostly short gaps, a few long ones, none at all in steady stretches.
    function automatic int unsigned idle_length(input bit steady);
        int unsigned r;
        if (steady)
            return 0;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(3, 1);
        else
            return $urandom_range(40, 8);
    endfunction

    // One SHA-1 compression of the buffered block into the chaining words.
    task automatic sha1_compress();
        logic [31:0] w [sha1mh_pkg::ROUNDS];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int i = 0; i < 16; i++)
            w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
        for (int i = 16; i < sha1mh_pkg::ROUNDS; i++)
        begin
            t = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
            w[i] = {t[30:0], t[31]};
        end
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        e = chain_h[4];
        for (int i = 0; i < sha1mh_pkg::ROUNDS; i++)
        begin
            if (i < 20)
            begin
                f = (b & c) | (~b & d);
                k = K_CH;
            end
            else if (i < 40)
            begin
                f = b ^ c ^ d;
                k = K_PAR;
            end
            else if (i < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = K_MAJ;
            end
            else
            begin
                f = b ^ c ^ d;
                k = K_END;
            end
            t = {a[26:0], a[31:27]} + f + e + w[i] + k;
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
        end
        chain_h[0] += a;
        chain_h[1] += b;
        chain_h[2] += c;
        chain_h[3] += d;
        chain_h[4] += e;
        buf_fill = 0;
    endtask

    // Start of a new message.
    task automatic sha1_restart();
        for (int i = 0; i < sha1mh_pkg::HASH_WORDS; i++)
            chain_h[i] = IV_WORD[i];
        buf_fill = 0;
        msg_bits = '0;
        len_wrapped = 1'b0;
    endtask

    // Predict the effect of one accepted request.
    task automatic sha1_absorb(input logic operation, input logic [7:0] data_byte);
        int unsigned pos;
        if (operation == sha1mh_pkg::OP_APPEND)
        begin
            block_buf[buf_fill] = data_byte;
            buf_fill++;
            bytes_hashed++;
            msg_bits += 64'd8;
            // The length wraps only after 2^61 bytes, far beyond any run.
            if (msg_bits == 64'd0)
                len_wrapped = 1'b1;
            if (buf_fill == sha1mh_pkg::BLOCK_BYTES)
                sha1_compress();
            return;
        end

        if (buf_fill == sha1mh_pkg::LEN_POS - 1)
            tails_one_block++;
        else if (buf_fill >= sha1mh_pkg::LEN_POS)
            tails_two_block++;
        else if (buf_fill == 0 && msg_bits != 64'd0)
            tails_aligned++;

        // Marker byte, then zeros; a tail past the length field needs an extra block.
        pos = buf_fill;
        block_buf[pos] = sha1mh_pkg::PAD_MARK;
        pos++;
        if (pos > sha1mh_pkg::LEN_POS)
        begin
            while (pos < sha1mh_pkg::BLOCK_BYTES)
            begin
                block_buf[pos] = 8'h00;
                pos++;
            end
            sha1_compress();
            pos = 0;
        end
        while (pos < sha1mh_pkg::LEN_POS)
        begin
            block_buf[pos] = 8'h00;
            pos++;
        end
        for (int i = 0; i < 8; i++)
            block_buf[sha1mh_pkg::LEN_POS + i] = msg_bits[63 - 8*i -: 8];
        sha1_compress();

        for (int i = 0; i < sha1mh_pkg::HASH_WORDS; i++)
            digest_expect_q.push_back('{chain_h[i], 3'(i),
                                        (i == sha1mh_pkg::HASH_WORDS - 1), len_wrapped});
        messages_hashed++;
        sha1_restart();
    endtask

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%s", msg);
    endtask

    // Compare one accepted digest word with the oldest prediction.
    task automatic check_digest_word();
        digest_word_t got;
        digest_word_t want;
        got = '{digest.digest_word, digest.word_index, digest.last_word, digest.status};
        words_checked++;
        if (digest_expect_q.size() == 0)
        begin
            note_failure($sformatf("Unexpected digest word %h index %0d last %0b status %0b",
                                   got.word, got.idx, got.last, got.status));
        end
        else
        begin
            want = digest_expect_q.pop_front();
            if (got.word !== want.word || got.idx !== want.idx ||
                got.last !== want.last || got.status !== want.status)
                note_failure($sformatf(
                    "Digest mismatch: expected %h/%0d/%0b/%0b, got %h/%0d/%0b/%0b",
                    want.word, want.idx, want.last, want.status,
                    got.word, got.idx, got.last, got.status));
        end
    endtask

    task automatic queue_request(input logic operation, input logic [7:0] data_byte);
        request_q.push_back('{operation, data_byte});
        queued_requests++;
    endtask

    // A message of random bytes; the byte sent with the finish is ignored.
    task automatic queue_message(input int unsigned len);
        for (int unsigned i = 0; i < len; i++)
            queue_request(sha1mh_pkg::OP_APPEND, 8'($urandom_range(255)));
        queue_request(sha1mh_pkg::OP_FINISH, 8'($urandom_range(255)));
    endtask

    // The sender stays quiet until every predicted word has been received.
    task automatic wait_for_drain();
        while (request_q.size() != 0 || feed.valid || digest_expect_q.size() != 0)
            @(negedge clk);
    endtask

    // Feed driver: presents queued requests and predicts each accepted one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            feed.valid     <= 1'b0;
            feed.operation <= sha1mh_pkg::OP_APPEND;
            feed.data_byte <= 8'h00;
            tx_idle        <= 0;
            tx_steady      <= 1'b0;
        end
        else
        begin
            if (feed.valid && feed.ready)
                sha1_absorb(feed.operation, feed.data_byte);
            if (!feed.valid || feed.ready)
            begin
                if (tx_idle != 0)
                begin
                    feed.valid <= 1'b0;
                    tx_idle    <= tx_idle - 1;
                end
                else if (request_q.size() != 0)
                begin
                    next_req = request_q.pop_front();
                    feed.valid     <= 1'b1;
                    feed.operation <= next_req.operation;
                    feed.data_byte <= next_req.data_byte;
                    tx_idle        <= idle_length(tx_steady);
                    if ($urandom_range(31) == 0)
                        tx_steady <= !tx_steady;
                end
                else
                begin
                    feed.valid <= 1'b0;
                end
            end
        end
    end

    // Long digest hold-off, started on request from the stimulus.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_hold_left  <= 0;
            rx_hold_given <= 0;
        end
        else if (rx_hold_given != rx_hold_asked)
        begin
            rx_hold_left  <= LONG_HOLD;
            rx_hold_given <= rx_hold_given + 1;
        end
        else if (rx_hold_left != 0)
        begin
            rx_hold_left <= rx_hold_left - 1;
        end
    end

    // Digest monitor: checks accepted words and paces the ready signal.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digest.ready <= 1'b0;
            rx_idle      <= 0;
            rx_steady    <= 1'b0;
        end
        else
        begin
            if (digest.valid && digest.ready)
                check_digest_word();
            if (rx_hold_left != 0)
            begin
                digest.ready <= 1'b0;
            end
            else if (rx_idle != 0)
            begin
                digest.ready <= 1'b0;
                rx_idle      <= rx_idle - 1;
            end
            else if ((digest.valid && digest.ready) || $urandom_range(15) == 0)
            begin
                rx_pick = idle_length(rx_steady);
                digest.ready <= (rx_pick == 0);
                rx_idle      <= (rx_pick == 0) ? 0 : rx_pick - 1;
                if ($urandom_range(31) == 0)
                    rx_steady <= !rx_steady;
            end
            else
            begin
                digest.ready <= 1'b1;
            end
        end
    end

    // Stimulus and end of run.
    initial
    begin
        rst_n            = 1'b0;
        sha1_restart();
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // Empty messages, one with a nonzero byte on the finish.
        queue_request(sha1mh_pkg::OP_FINISH, 8'h00);
        queue_request(sha1mh_pkg::OP_FINISH, 8'hFF);
        // The classic three-byte message "abc".
        queue_request(sha1mh_pkg::OP_APPEND, 8'h61);
        queue_request(sha1mh_pkg::OP_APPEND, 8'h62);
        queue_request(sha1mh_pkg::OP_APPEND, 8'h63);
        queue_request(sha1mh_pkg::OP_FINISH, 8'h00);
        // Byte extremes and alternating bit patterns.
        queue_request(sha1mh_pkg::OP_APPEND, 8'h00);
        queue_request(sha1mh_pkg::OP_FINISH, 8'h55);
        queue_request(sha1mh_pkg::OP_APPEND, 8'hFF);
        queue_request(sha1mh_pkg::OP_FINISH, 8'hAA);
        queue_request(sha1mh_pkg::OP_APPEND, 8'h00);
        queue_request(sha1mh_pkg::OP_APPEND, 8'hFF);
        queue_request(sha1mh_pkg::OP_APPEND, 8'h55);
        queue_request(sha1mh_pkg::OP_APPEND, 8'hAA);
        queue_request(sha1mh_pkg::OP_APPEND, 8'h80);
        queue_request(sha1mh_pkg::OP_APPEND, 8'h01);
        queue_request(sha1mh_pkg::OP_FINISH, 8'hFF);
        wait_for_drain();

        // Digest side stalls for a long stretch while short messages keep coming.
        rx_hold_asked++;
        queue_message(3);
        queue_message(0);
        queue_message(10);
        queue_message(2);

        // Tails at the padding boundaries: one block, two blocks, block-aligned.
        queue_message(sha1mh_pkg::LEN_POS - 1);
        queue_message(sha1mh_pkg::LEN_POS);
        queue_message(sha1mh_pkg::BLOCK_BYTES);
        wait_for_drain();

        // Random messages, mostly short, some spanning a block boundary.
        while (queued_requests < REQUEST_GOAL)
        begin
            if ($urandom_range(9) == 0)
                queue_message($urandom_range(80, 57));
            else
                queue_message($urandom_range(20, 0));
            if ($urandom_range(7) == 0)
                wait_for_drain();
        end
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Hashed %0d messages from %0d bytes: %0d one-block tails, %0d two-block tails,",
                 messages_hashed, bytes_hashed, tails_one_block, tails_two_block);
        $display("%0d block-aligned messages; %0d digest words checked, %0d failures.",
                 tails_aligned, words_checked, fail_count + digest_expect_q.size());
        if (fail_count == 0 && digest_expect_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #3_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
